FILE: rtl/core/hdts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hdts_pkg;

    // item kinds
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register selectors
    localparam logic [2:0] SEL_DIV  = 3'd0;
    localparam logic [2:0] SEL_TIMA = 3'd1;
    localparam logic [2:0] SEL_TMA  = 3'd2;
    localparam logic [2:0] SEL_TAC  = 3'd3;
    localparam logic [2:0] SEL_SC   = 3'd4;
    localparam logic [2:0] SEL_IF   = 3'd5;

    // clock mode codes
    localparam logic [1:0] MODE_X1  = 2'd0;
    localparam logic [1:0] MODE_X64 = 2'd1;
    localparam logic [1:0] MODE_X16 = 2'd2;
    localparam logic [1:0] MODE_X4  = 2'd3;

    localparam logic [7:0] TAC_RESET = 8'hF8;
    localparam logic [7:0] IF_RESET  = 8'hE1;
    localparam logic [7:0] CNT_FULL  = 8'hFF;
    localparam logic [7:0] RELOAD_BELOW = 8'd5;
    localparam logic [12:0] TWO_CARRY = 13'h1FE;
    localparam logic [3:0] SC_LAST_CARRY = 4'hF;

    localparam int TUSER_W = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [5:0] cycles_elapsed;
        logic [7:0] write_data;
        logic [2:0] reg_select;
        logic [1:0] command;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/handheld_divider_timer_serial.sv
`timescale 1ns / 1ps
`default_nettype none
// an item goes from the input register to the result register, which drives m_tvalid
// throughput: one item per cycle unless m_tready stalls; all items take the same single pass
// the timer state is updated in the cycle an item moves from input to result register
// reset (aresetn low, synchronous) clears both stages and restores the register reset values
module handheld_divider_timer_serial
    import hdts_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // write_data[7:0], cycles_elapsed[13:8]
    input  wire logic [TUSER_W-1:0]   s_tuser,   // command[1:0], reg_select[4:2]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // read_data[7:0], timer_irq[8], serial_done[9]
);

    logic  in_valid_reg;
    item_t in_reg;
    logic  out_valid_reg;
    logic [7:0] out_rd_reg;
    logic  out_irq_reg, out_done_reg;

    logic [7:0] div_reg, div_next;
    logic [7:0] dpre_reg, dpre_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] tpre_reg, tpre_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] tma_reg, tma_next;
    logic [7:0] tac_reg, tac_next;
    logic [7:0] sc_reg, sc_next;
    logic       sbusy_reg, sbusy_next;
    logic [3:0] scar_reg, scar_next;
    logic [7:0] if_reg, if_next;

    logic       advance;
    logic [7:0] rd;
    logic       irq, done;
    logic [8:0] dsum;
    logic [12:0] dur, tsum;
    logic [7:0] cnt_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        unique case (tac_reg[1:0])
            MODE_X1:  dur = {7'd0, in_reg.cycles_elapsed};
            MODE_X64: dur = {1'b0, in_reg.cycles_elapsed, 6'd0};
            MODE_X16: dur = {3'd0, in_reg.cycles_elapsed, 4'd0};
            MODE_X4:  dur = {5'd0, in_reg.cycles_elapsed, 2'd0};
        endcase
    end

    assign dsum = {1'b0, dpre_reg} + {1'b0, in_reg.cycles_elapsed, 2'b00};
    assign tsum = {5'd0, tpre_reg} + dur;
    assign cnt_inc = cnt_reg + {7'd0, tsum > 13'h0FF} + {7'd0, tsum > TWO_CARRY};

    always_comb begin
        div_next   = div_reg;
        dpre_next  = dpre_reg;
        cnt_next   = cnt_reg;
        tpre_next  = tpre_reg;
        prev_next  = prev_reg;
        tma_next   = tma_reg;
        tac_next   = tac_reg;
        sc_next    = sc_reg;
        sbusy_next = sbusy_reg;
        scar_next  = scar_reg;
        if_next    = if_reg;
        rd   = 8'd0;
        irq  = 1'b0;
        done = 1'b0;
        unique case (in_reg.command)
            CMD_TICK: begin
                dpre_next = dsum[7:0];
                if (dsum[8]) begin
                    div_next = div_reg + 8'd1;
                    if (sbusy_reg) begin
                        if (scar_reg == SC_LAST_CARRY) begin
                            scar_next  = 4'd0;
                            sc_next    = {1'b0, sc_reg[6:0]};
                            sbusy_next = 1'b0;
                            done       = 1'b1;
                        end else begin
                            scar_next = scar_reg + 4'd1;
                        end
                    end
                end
                if (tac_reg[2]) begin
                    tpre_next = tsum[7:0];
                    // overflow seen as a wrap from all ones to a small value
                    if (cnt_inc < RELOAD_BELOW && prev_reg == CNT_FULL) begin
                        cnt_next  = tma_reg;
                        prev_next = tma_reg;
                        if_next   = if_reg | 8'h04;
                        irq       = 1'b1;
                    end else begin
                        cnt_next  = cnt_inc;
                        prev_next = cnt_inc;
                    end
                end
            end
            CMD_WRITE: begin
                unique case (in_reg.reg_select)
                    SEL_DIV:  div_next = 8'd0;
                    SEL_TIMA: cnt_next = in_reg.write_data;
                    SEL_TMA:  tma_next = in_reg.write_data;
                    SEL_TAC:  tac_next = in_reg.write_data;
                    SEL_SC: begin
                        sc_next = in_reg.write_data;
                        if (in_reg.write_data[7]) begin
                            sbusy_next = 1'b1;
                        end
                    end
                    SEL_IF:   if_next = in_reg.write_data;
                    default: ;
                endcase
            end
            CMD_READ: begin
                unique case (in_reg.reg_select)
                    SEL_DIV:  rd = div_reg;
                    SEL_TIMA: rd = cnt_reg;
                    SEL_TMA:  rd = tma_reg;
                    SEL_TAC:  rd = tac_reg;
                    SEL_SC:   rd = sc_reg;
                    SEL_IF:   rd = if_reg;
                    default:  rd = 8'd0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            div_reg   <= 8'd0;
            dpre_reg  <= 8'd0;
            cnt_reg   <= 8'd0;
            tpre_reg  <= 8'd0;
            prev_reg  <= 8'd0;
            tma_reg   <= 8'd0;
            tac_reg   <= TAC_RESET;
            sc_reg    <= 8'd0;
            sbusy_reg <= 1'b0;
            scar_reg  <= 4'd0;
            if_reg    <= IF_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                div_reg   <= div_next;
                dpre_reg  <= dpre_next;
                cnt_reg   <= cnt_next;
                tpre_reg  <= tpre_next;
                prev_reg  <= prev_next;
                tma_reg   <= tma_next;
                tac_reg   <= tac_next;
                sc_reg    <= sc_next;
                sbusy_reg <= sbusy_next;
                scar_reg  <= scar_next;
                if_reg    <= if_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.command        <= s_tuser[1:0];
            in_reg.reg_select     <= s_tuser[4:2];
            in_reg.write_data     <= s_tdata[7:0];
            in_reg.cycles_elapsed <= s_tdata[13:8];
        end
        if (advance) begin
            out_rd_reg   <= rd;
            out_irq_reg  <= irq;
            out_done_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_done_reg, out_irq_reg, out_rd_reg};

endmodule

`default_nettype wire

FILE: dv/handheld_divider_timer_serial_test.sv
`timescale 1ns / 1ps

module handheld_divider_timer_serial_test;
    import hdts_pkg::*;

    // codes the block must ignore
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] SEL_SPARE   = 3'd6;
    localparam logic [2:0] SEL_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       serial_done;
    } timer_result_t;

    class timer_scoreboard;
        logic [7:0]      div_q;
        logic [7:0]      div_pre;
        logic [7:0]      tima;
        logic [7:0]      tima_pre;
        logic [7:0]      tima_last;
        logic [7:0]      tma;
        logic [7:0]      tac;
        logic            tmr_on;
        logic [1:0]      mode;
        logic [7:0]      sc;
        logic            xfer_busy;
        logic [3:0]      xfer_carries;
        logic [7:0]      irq_flags;
        timer_result_t   outstanding[$];
        int              errors;

        function new();
            div_q        = '0;
            div_pre      = '0;
            tima         = '0;
            tima_pre     = '0;
            tima_last    = '0;
            tma          = '0;
            tac          = TAC_RESET;
            tmr_on       = 1'b0;
            mode         = MODE_X1;
            sc           = '0;
            xfer_busy    = 1'b0;
            xfer_carries = '0;
            irq_flags    = IF_RESET;
            errors       = 0;
        endfunction

        // advance the timer model by one accepted item and queue its result
        function void note_item(logic [1:0] cmd, logic [2:0] sel, logic [7:0] wd,
                                logic [5:0] n);
            timer_result_t res;
            int unsigned   steps;
            int unsigned   dsum;
            int unsigned   tsum;
            res   = '0;
            steps = {26'd0, n};
            case (cmd)
                CMD_TICK: begin
                    dsum = {24'd0, div_pre} + (steps << 2);
                    if (dsum > 255) begin
                        div_q = div_q + 8'd1;
                        if (xfer_busy) begin
                            if (xfer_carries == SC_LAST_CARRY) begin
                                xfer_carries    = '0;
                                sc[7]           = 1'b0;
                                xfer_busy       = 1'b0;
                                res.serial_done = 1'b1;
                            end else begin
                                xfer_carries = xfer_carries + 4'd1;
                            end
                        end
                    end
                    div_pre = dsum[7:0];
                    if (tmr_on) begin
                        tsum = {24'd0, tima_pre};
                        case (mode)
                            MODE_X1:  tsum = tsum + steps;
                            MODE_X64: tsum = tsum + (steps << 6);
                            MODE_X16: tsum = tsum + (steps << 4);
                            default:  tsum = tsum + (steps << 2);
                        endcase
                        if (tsum > 255) tima = tima + 8'd1;
                        if (tsum > {19'd0, TWO_CARRY}) tima = tima + 8'd1;
                        tima_pre = tsum[7:0];
                        if (tima < RELOAD_BELOW && tima_last == CNT_FULL) begin
                            tima          = tma;
                            irq_flags[2]  = 1'b1;
                            res.timer_irq = 1'b1;
                        end
                        tima_last = tima;
                    end
                end
                CMD_WRITE: begin
                    case (sel)
                        SEL_DIV:  div_q = '0;
                        SEL_TIMA: tima = wd;
                        SEL_TMA:  tma = wd;
                        SEL_TAC: begin
                            tmr_on = wd[2];
                            mode   = wd[1:0];
                            tac    = wd;
                        end
                        SEL_SC: begin
                            if (wd[7]) xfer_busy = 1'b1;
                            sc = wd;
                        end
                        SEL_IF:   irq_flags = wd;
                        default: ;
                    endcase
                end
                CMD_READ: begin
                    case (sel)
                        SEL_DIV:  res.read_data = div_q;
                        SEL_TIMA: res.read_data = tima;
                        SEL_TMA:  res.read_data = tma;
                        SEL_TAC:  res.read_data = tac;
                        SEL_SC:   res.read_data = sc;
                        SEL_IF:   res.read_data = irq_flags;
                        default:  res.read_data = '0;
                    endcase
                end
                default: ;
            endcase
            outstanding.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            timer_result_t want;
            if (outstanding.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: m_tdata %h", word);
                return;
            end
            want = outstanding.pop_front();
            if (word[7:0] !== want.read_data || word[8] !== want.timer_irq ||
                word[9] !== want.serial_done) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: read_data %h/%h timer_irq %b/%b serial_done %b/%b",
                             want.read_data, word[7:0], want.timer_irq, word[8],
                             want.serial_done, word[9]);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // write_data[7:0], cycles_elapsed[13:8]
    logic [TUSER_W-1:0]   s_tuser  = '0;   // command[1:0], reg_select[4:2]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // read_data[7:0], timer_irq[8], serial_done[9]

    int unsigned     send_idle  = 0;
    int unsigned     recv_stall = 0;
    int unsigned     cycle_count = 0;
    timer_scoreboard timer_sb = new();

    handheld_divider_timer_serial u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("handheld_divider_timer_serial_test: done, errors");
            $finish;
        end
    end

    // result side: random back-pressure, check every accepted item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            timer_sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(logic [1:0] cmd, logic [2:0] sel, logic [7:0] wd,
                             logic [5:0] n);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, n, wd};
        s_tuser  <= {sel, cmd};
        do @(posedge aclk); while (!s_tready);
        timer_sb.note_item(cmd, sel, wd, n);
    endtask

    // mostly ticks with control, counter and serial writes that steer the
    // timer towards overflow and keep transfers running
    task automatic send_random_item();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [2:0]  sel;
        logic [7:0]  wd;
        logic [5:0]  n;
        pick = $urandom_range(99);
        sel  = 3'($urandom_range(5));
        wd   = 8'($urandom);
        n    = 6'($urandom);
        if (pick < 55) begin
            cmd = CMD_TICK;
            if ($urandom_range(3) == 0) n = 6'($urandom_range(3));
        end else if (pick < 78) begin
            cmd = CMD_WRITE;
            if ($urandom_range(19) == 0) sel = 3'($urandom_range(7));
            if (sel == SEL_TIMA && $urandom_range(1)) wd = 8'hF0 | 8'($urandom_range(15));
            if (sel == SEL_TAC && $urandom_range(4) != 0) wd[2] = 1'b1;
            if (sel == SEL_IF && $urandom_range(1)) wd[2] = 1'b0;
        end else if (pick < 97) begin
            cmd = CMD_READ;
            if ($urandom_range(9) == 0) sel = 3'($urandom_range(7));
        end else begin
            cmd = CMD_UNUSED;
            sel = 3'($urandom_range(7));
        end
        send_item(cmd, sel, wd, n);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle  = 24;
        recv_stall = 53;

        // reset values, ignored selectors and command
        send_item(CMD_READ,   SEL_TAC,     8'h00, 6'd0);
        send_item(CMD_READ,   SEL_IF,      8'hFF, 6'd63);
        send_item(CMD_READ,   SEL_SPARE_B, 8'h00, 6'd0);
        send_item(CMD_UNUSED, SEL_SPARE_B, 8'hFF, 6'd63);
        send_item(CMD_WRITE,  SEL_SPARE,   8'hFF, 6'd63);
        // timer off: only the divider moves
        send_item(CMD_TICK,   SEL_DIV,     8'hFF, 6'd63);
        send_item(CMD_TICK,   SEL_DIV,     8'h00, 6'd0);
        send_item(CMD_TICK,   SEL_DIV,     8'h00, 6'd63);
        send_item(CMD_READ,   SEL_DIV,     8'h00, 6'd0);
        send_item(CMD_WRITE,  SEL_DIV,     8'hFF, 6'd0);
        send_item(CMD_READ,   SEL_DIV,     8'h00, 6'd0);
        // counter overflow and reload from modulo
        send_item(CMD_WRITE,  SEL_TMA,     8'hAB, 6'd0);
        send_item(CMD_WRITE,  SEL_TIMA,    8'hFD, 6'd0);
        send_item(CMD_WRITE,  SEL_TAC,     {5'b00000, 1'b1, MODE_X64}, 6'd0);
        send_item(CMD_TICK,   SEL_DIV,     8'h00, 6'd4);
        send_item(CMD_TICK,   SEL_DIV,     8'h00, 6'd4);
        send_item(CMD_TICK,   SEL_DIV,     8'h00, 6'd4);
        send_item(CMD_READ,   SEL_TIMA,    8'h00, 6'd0);
        send_item(CMD_READ,   SEL_IF,      8'h00, 6'd0);
        // transfer start, then bit 7 cleared while still busy
        send_item(CMD_WRITE,  SEL_SC,      8'h81, 6'd0);
        send_item(CMD_WRITE,  SEL_SC,      8'h01, 6'd0);
        send_item(CMD_TICK,   SEL_SC,      8'h00, 6'd63);
        send_item(CMD_READ,   SEL_SC,      8'h00, 6'd0);
        send_item(CMD_WRITE,  SEL_IF,      8'h00, 6'd0);

        repeat (PHASE_ITEMS) send_random_item();
        send_idle  = 53;
        recv_stall = 24;
        repeat (PHASE_ITEMS) send_random_item();
        send_idle  = 0;
        recv_stall = 0;
        repeat (PHASE_ITEMS) send_random_item();
        s_tvalid <= 1'b0;

        while (timer_sb.outstanding.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (timer_sb.errors == 0 && timer_sb.outstanding.size() == 0)
            $display("handheld_divider_timer_serial_test: done, clean");
        else
            $display("handheld_divider_timer_serial_test: done, errors");
        $finish;
    end

endmodule
